>>> sv/uwvc_pkg.sv
`default_nettype none

package uwvc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int NUM_VOWELS  = 6;
    localparam int OUT_BITS    = OUT_WIDTH * (NUM_VOWELS + 1);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [7:0] LEAD_2 = 8'd192;
    localparam logic [7:0] LEAD_3 = 8'd224;
    localparam logic [7:0] LEAD_4 = 8'd240;

    typedef logic [2:0] t_cls;

    localparam t_cls CLS_A     = 3'd0;
    localparam t_cls CLS_E     = 3'd1;
    localparam t_cls CLS_I     = 3'd2;
    localparam t_cls CLS_O     = 3'd3;
    localparam t_cls CLS_U     = 3'd4;
    localparam t_cls CLS_Y     = 3'd5;
    localparam t_cls CLS_SEP   = 3'd6;
    localparam t_cls CLS_OTHER = 3'd7;

    localparam logic [31:0] CODE_APOS     = 32'h0000_0027;
    localparam logic [31:0] CODE_GRAVE    = 32'h0000_0060;
    localparam logic [31:0] CODE_LSQUOTE  = 32'h00e2_8098;
    localparam logic [31:0] CODE_RSQUOTE  = 32'h00e2_8099;

    // one entry between front and back
    typedef struct packed {
        logic has_char;
        t_cls cls;
        logic last;
    } t_qent;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    function automatic logic is_quiet(input logic [31:0] code);
        return (code == CODE_APOS) || (code == CODE_GRAVE) ||
               (code == CODE_LSQUOTE) || (code == CODE_RSQUOTE);
    endfunction

    // 0xc3bd is classified as u, not y
    function automatic t_cls classify(input logic [31:0] code);
        t_cls c;
        case (code)
            32'h41, 32'h61, 32'hc380, 32'hc381, 32'hc382, 32'hc383,
            32'hc384, 32'hc385, 32'hc386, 32'hc3a0, 32'hc3a1, 32'hc3a2,
            32'hc3a3, 32'hc3a4, 32'hc3a5, 32'hc3a6:
                c = CLS_A;
            32'h45, 32'h65, 32'hc388, 32'hc389, 32'hc38a, 32'hc38b,
            32'hc3a8, 32'hc3a9, 32'hc3aa, 32'hc3ab:
                c = CLS_E;
            32'h49, 32'h69, 32'hc38c, 32'hc38d, 32'hc38e, 32'hc38f,
            32'hc3ac, 32'hc3ad, 32'hc3ae, 32'hc2af:
                c = CLS_I;
            32'h4f, 32'h6f, 32'hc392, 32'hc393, 32'hc394, 32'hc395,
            32'hc396, 32'hc398, 32'hc3b2, 32'hc3b3, 32'hc3b4, 32'hc3b5,
            32'hc3b6, 32'hc3b8:
                c = CLS_O;
            32'h55, 32'h75, 32'hc399, 32'hc39a, 32'hc39b, 32'hc39c,
            32'hc3b9, 32'hc3ba, 32'hc3bb, 32'hc3bc, 32'hc3bd:
                c = CLS_U;
            32'h59, 32'h79, 32'hc39d, 32'hc3bf:
                c = CLS_Y;
            32'h20, 32'h27, 32'h60, 32'he28098, 32'he28099, 32'h09,
            32'h0a, 32'h0d, 32'h22, 32'h2d, 32'he2809c, 32'he2809d,
            32'h5b, 32'h5d, 32'h28, 32'h29, 32'h2c, 32'h2e, 32'h3a,
            32'h3b, 32'h3f, 32'h21, 32'he28093, 32'he280a6, 32'h5f,
            32'hc2bb, 32'hc2ab, 32'hc2a8, 32'he28094:
                c = CLS_SEP;
            default:
                c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/uwvc_front.sv
`default_nettype none

module uwvc_front
    import uwvc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_push,
    output t_qent           o_ent,
    input  wire logic       i_q_ready
);

    logic [23:0] r_char;
    logic [1:0]  r_left;
    logic [23:0] n_char;
    logic [1:0]  n_left;
    logic        start;
    logic [1:0]  len_m1;
    logic [31:0] code;
    logic        done;
    logic        accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid & i_q_ready;

    always_comb begin
        start = (r_left == 2'd0);
        if (i_byte < LEAD_2) begin
            len_m1 = 2'd0;
        end else if (i_byte < LEAD_3) begin
            len_m1 = 2'd1;
        end else if (i_byte < LEAD_4) begin
            len_m1 = 2'd2;
        end else begin
            len_m1 = 2'd3;
        end
        code   = start ? {24'd0, i_byte} : {r_char, i_byte};
        n_left = start ? len_m1 : r_left - 2'd1;
        n_char = code[23:0];
        done   = (n_left == 2'd0);
    end

    always_comb begin
        o_ent.has_char = done & ~is_quiet(code);
        o_ent.cls      = classify(code);
        o_ent.last     = i_last;
        o_push         = accept & (o_ent.has_char | i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (accept) begin
            // a partial character at the end of a chunk is dropped
            r_left <= i_last ? 2'd0 : n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= n_char;
        end
    end

endmodule

`default_nettype wire

>>> sv/uwvc_fifo.sv
`default_nettype none

module uwvc_fifo
    import uwvc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_qent      i_ent,
    output logic       o_ready,
    output logic       o_valid,
    output t_qent      o_ent,
    input  wire logic  i_pop
);

    t_qent                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 push;
    logic                 pop;

    assign o_ready = (r_cnt != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign push    = i_push & o_ready;
    assign pop     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

`default_nettype wire

>>> sv/uwvc_back.sv
`default_nettype none

module uwvc_back
    import uwvc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  t_qent                    i_ent,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OUT_BITS-1:0]      o_data
);

    t_cnt                r_words;
    t_cnt                r_vcnt [NUM_VOWELS];
    logic                r_inside;
    logic [NUM_VOWELS-1:0] r_mask;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    t_cnt                n_words;
    t_cnt                n_vcnt [NUM_VOWELS];
    logic                n_inside;
    logic [NUM_VOWELS-1:0] n_mask;
    logic [OUT_BITS-1:0] n_out_data;
    logic                out_free;
    logic                load;

    assign out_free = ~r_out_valid | i_ready;
    assign o_pop    = i_valid & (~i_ent.last | out_free);
    assign load     = o_pop & i_ent.last;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    always_comb begin
        n_words  = r_words;
        n_inside = r_inside;
        n_mask   = r_mask;
        for (int k = 0; k < NUM_VOWELS; k++) begin
            n_vcnt[k] = r_vcnt[k];
        end
        if (i_ent.has_char) begin
            if (i_ent.cls == CLS_SEP) begin
                if (r_inside) begin
                    n_words  = (r_words == '1) ? r_words : r_words + 1'b1;
                    n_mask   = '0;
                    n_inside = 1'b0;
                end
            end else begin
                n_inside = 1'b1;
                for (int k = 0; k < NUM_VOWELS; k++) begin
                    if (i_ent.cls == t_cls'(k) && !r_mask[k]) begin
                        n_vcnt[k] = (r_vcnt[k] == '1) ? r_vcnt[k] : r_vcnt[k] + 1'b1;
                        n_mask[k] = 1'b1;
                    end
                end
            end
        end
        n_out_data[OUT_WIDTH-1:0] = OUT_WIDTH'(n_words);
        for (int k = 0; k < NUM_VOWELS; k++) begin
            n_out_data[(k+1)*OUT_WIDTH +: OUT_WIDTH] = OUT_WIDTH'(n_vcnt[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words     <= '0;
            r_inside    <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_VOWELS; k++) begin
                r_vcnt[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                if (i_ent.last) begin
                    // chunk done: result goes out, state starts over
                    r_words  <= '0;
                    r_inside <= 1'b0;
                    r_mask   <= '0;
                    for (int k = 0; k < NUM_VOWELS; k++) begin
                        r_vcnt[k] <= '0;
                    end
                end else begin
                    r_words  <= n_words;
                    r_inside <= n_inside;
                    r_mask   <= n_mask;
                    for (int k = 0; k < NUM_VOWELS; k++) begin
                        r_vcnt[k] <= n_vcnt[k];
                    end
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/utf8_word_vowel_counter.sv
// Counts words and words per vowel class (a, e, i, o, u, y, accented forms
// included) in a chunk of UTF-8 text fed one byte per item; the last byte
// of a chunk carries tlast and produces one result item with all seven
// counts, after which the counters start again from zero. The block takes
// one byte every clock cycle while the queue has room: the front decodes
// and classifies each byte in the cycle it arrives, a 4-entry queue carries
// characters to the counter stage, and the counter stage retires one entry
// per cycle; a stalled output only holds back the queue entry of the next
// chunk end, so input keeps flowing until the queue fills. The result item
// leaves through an output register. Words still open at the end of a chunk
// and partial characters are not counted; counts saturate.
`default_nettype none

module utf8_word_vowel_counter
    import uwvc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [7:0]          i_s_tdata,   // [7:0] data_byte
    input  wire logic                i_s_tlast,   // end_of_chunk
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // word_total, words_with_a, _e, _i, _o, _u, _y; 16 bits each, from bit 0
    output logic [OUT_BITS-1:0]      o_m_tdata
);

    logic  front_push;
    t_qent front_ent;
    logic  q_ready;
    logic  q_valid;
    t_qent q_ent;
    logic  back_pop;

    uwvc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_push    (front_push),
        .o_ent     (front_ent),
        .i_q_ready (q_ready)
    );

    uwvc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_ent   (front_ent),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (back_pop)
    );

    uwvc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_ent   (q_ent),
        .o_pop   (back_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule

`default_nettype wire

>>> sv/uwvc_checker.sv
`default_nettype none

module uwvc_checker
    import uwvc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                o_s_tready,
    input  wire logic                i_s_tlast,
    input  wire logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [OUT_BITS-1:0] o_m_tdata
);

    // chunk ends taken whose result has not yet been delivered
    logic [3:0] r_pend;
    logic       in_last;
    logic       out_take;

    assign in_last  = i_s_tvalid & o_s_tready & i_s_tlast;
    assign out_take = o_m_tvalid & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_last && !out_take) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_take && !in_last) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_result_has_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_pend != 4'd0))
        else $error("result without a preceding chunk end");

    a_pend_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'(FIFO_DEPTH + 1))
        else $error("more chunk ends in flight than the queue can hold");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind utf8_word_vowel_counter uwvc_checker u_uwvc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

>>> tb/tb_utf8_word_vowel_counter.sv
`timescale 1ns / 100ps

module tb_utf8_word_vowel_counter;
    import uwvc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 200_000;

    // class lists; order within a list does not matter, the lists are searched a..y then sep
    localparam logic [15:0][31:0] A_CODES = {
        32'h41, 32'h61, 32'hc380, 32'hc381, 32'hc382, 32'hc383, 32'hc384, 32'hc385,
        32'hc386, 32'hc3a0, 32'hc3a1, 32'hc3a2, 32'hc3a3, 32'hc3a4, 32'hc3a5, 32'hc3a6};
    localparam logic [9:0][31:0] E_CODES = {
        32'h45, 32'h65, 32'hc388, 32'hc389, 32'hc38a, 32'hc38b,
        32'hc3a8, 32'hc3a9, 32'hc3aa, 32'hc3ab};
    localparam logic [9:0][31:0] I_CODES = {
        32'h49, 32'h69, 32'hc38c, 32'hc38d, 32'hc38e, 32'hc38f,
        32'hc3ac, 32'hc3ad, 32'hc3ae, 32'hc2af};
    localparam logic [13:0][31:0] O_CODES = {
        32'h4f, 32'h6f, 32'hc392, 32'hc393, 32'hc394, 32'hc395, 32'hc396,
        32'hc398, 32'hc3b2, 32'hc3b3, 32'hc3b4, 32'hc3b5, 32'hc3b6, 32'hc3b8};
    localparam logic [10:0][31:0] U_CODES = {
        32'h55, 32'h75, 32'hc399, 32'hc39a, 32'hc39b, 32'hc39c,
        32'hc3b9, 32'hc3ba, 32'hc3bb, 32'hc3bc, 32'hc3bd};
    localparam logic [4:0][31:0] Y_CODES = {
        32'h59, 32'h79, 32'hc39d, 32'hc3bd, 32'hc3bf};
    localparam logic [28:0][31:0] SEP_CODES = {
        32'h20, 32'h27, 32'h60, 32'he28098, 32'he28099, 32'h09, 32'h0a, 32'h0d,
        32'h22, 32'h2d, 32'he2809c, 32'he2809d, 32'h5b, 32'h5d, 32'h28, 32'h29,
        32'h2c, 32'h2e, 32'h3a, 32'h3b, 32'h3f, 32'h21, 32'he28093, 32'he280a6,
        32'h5f, 32'hc2bb, 32'hc2ab, 32'hc2a8, 32'he28094};

    typedef struct packed {
        logic [7:0]          b;
        logic                last;
        logic                pin;
        logic [OUT_BITS-1:0] want;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata;
    logic                i_s_tlast;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OUT_BITS-1:0] o_m_tdata;

    // byte-level text model
    logic [31:0] char_buf;
    logic [2:0]  char_pending;
    logic        word_open;
    logic [5:0]  vowels_in_word;
    t_cnt        word_cnt;
    t_cnt        vowel_cnt [NUM_VOWELS];

    logic [OUT_BITS-1:0] pending_counts [$];
    t_stim_row           stim_rows [$];
    logic [7:0]          text_q [$];

    int       burst_left = 0;
    int       errors = 0;
    int       results_seen = 0;
    int       bytes_sent = 0;
    int       chunks_sent = 0;
    int       cycles = 0;
    int       rx_left = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_OPEN;

    utf8_word_vowel_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // [7:0] data_byte
        .i_s_tlast  (i_s_tlast),    // end_of_chunk
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)     // word_total, a, e, i, o, u, y; 16 bits each
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_cls code_class(input logic [31:0] code);
        for (int k = 0; k < 16; k++) if (A_CODES[k] == code) return CLS_A;
        for (int k = 0; k < 10; k++) if (E_CODES[k] == code) return CLS_E;
        for (int k = 0; k < 10; k++) if (I_CODES[k] == code) return CLS_I;
        for (int k = 0; k < 14; k++) if (O_CODES[k] == code) return CLS_O;
        for (int k = 0; k < 11; k++) if (U_CODES[k] == code) return CLS_U;
        for (int k = 0; k < 5; k++)  if (Y_CODES[k] == code) return CLS_Y;
        for (int k = 0; k < 29; k++) if (SEP_CODES[k] == code) return CLS_SEP;
        return CLS_OTHER;
    endfunction

    function automatic t_cnt bump(input t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] pack_counts(input int w, a, e, i, o, u, y);
        return {OUT_WIDTH'(y), OUT_WIDTH'(u), OUT_WIDTH'(o), OUT_WIDTH'(i),
                OUT_WIDTH'(e), OUT_WIDTH'(a), OUT_WIDTH'(w)};
    endfunction

    function automatic string field_name(input int k);
        case (k)
            0: return "word_total";
            1: return "words_with_a";
            2: return "words_with_e";
            3: return "words_with_i";
            4: return "words_with_o";
            5: return "words_with_u";
            default: return "words_with_y";
        endcase
    endfunction

    function automatic logic [31:0] vowel_code(input int cls);
        case (cls)
            0: return A_CODES[$urandom_range(0, 15)];
            1: return E_CODES[$urandom_range(0, 9)];
            2: return I_CODES[$urandom_range(0, 9)];
            3: return O_CODES[$urandom_range(0, 13)];
            4: return U_CODES[$urandom_range(0, 10)];
            default: return Y_CODES[$urandom_range(0, 4)];
        endcase
    endfunction

    task automatic clear_text_state();
        char_buf       = '0;
        char_pending   = '0;
        word_open      = 1'b0;
        vowels_in_word = '0;
        word_cnt       = '0;
        for (int k = 0; k < NUM_VOWELS; k++) vowel_cnt[k] = '0;
    endtask

    task automatic take_char(input logic [31:0] code);
        t_cls cls;
        logic quiet;
        cls   = code_class(code);
        quiet = (code == CODE_APOS) || (code == CODE_GRAVE) ||
                (code == CODE_LSQUOTE) || (code == CODE_RSQUOTE);
        if (cls < CLS_SEP) begin
            word_open = 1'b1;
            if (!vowels_in_word[cls]) begin
                vowel_cnt[cls]      = bump(vowel_cnt[cls]);
                vowels_in_word[cls] = 1'b1;
            end
        end else if (cls == CLS_SEP) begin
            if (!quiet && word_open) begin
                word_cnt       = bump(word_cnt);
                vowels_in_word = '0;
                word_open      = 1'b0;
            end
        end else begin
            word_open = 1'b1;
        end
    endtask

    task automatic count_byte(input logic [7:0] b, input logic last,
                              output logic [OUT_BITS-1:0] res);
        if (char_pending == 0) begin
            char_pending = (b < LEAD_2) ? 3'd1 : (b < LEAD_3) ? 3'd2 :
                           (b < LEAD_4) ? 3'd3 : 3'd4;
            char_buf = '0;
        end
        char_buf     = {char_buf[23:0], b};
        char_pending = char_pending - 1'b1;
        if (char_pending == 0) take_char(char_buf);
        res = '0;
        if (last) begin
            res[OUT_WIDTH-1:0] = word_cnt[OUT_WIDTH-1:0];
            for (int k = 0; k < NUM_VOWELS; k++)
                res[(k + 1) * OUT_WIDTH +: OUT_WIDTH] = vowel_cnt[k][OUT_WIDTH-1:0];
            clear_text_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input logic pin,
                             input logic [OUT_BITS-1:0] want);
        int gap;
        logic [OUT_BITS-1:0] res;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 16);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
        count_byte(b, last, res);
        if (last) begin
            chunks_sent++;
            pending_counts.push_back(pin ? want : res);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic last);
        stim_rows.push_back('{b: b, last: last, pin: 1'b0, want: '0});
    endtask

    task automatic add_pinned(input logic [7:0] b, input logic [OUT_BITS-1:0] want);
        stim_rows.push_back('{b: b, last: 1'b1, pin: 1'b1, want: want});
    endtask

    task automatic add_code(input logic [31:0] code);
        int n;
        if (code[31:24] != 0)      n = 4;
        else if (code[23:16] != 0) n = 3;
        else if (code[15:8] != 0)  n = 2;
        else                       n = 1;
        for (int k = n - 1; k >= 0; k--) text_q.push_back(code[8 * k +: 8]);
    endtask

    task automatic add_random_char();
        int pick;
        logic [7:0] b0, b1, b2, b3;
        pick = $urandom_range(0, 99);
        b0   = 8'($urandom_range(0, 255));
        b1   = 8'($urandom_range(0, 255));
        b2   = 8'($urandom_range(0, 255));
        b3   = 8'($urandom_range(0, 255));
        if (pick < 35)
            add_code(vowel_code($urandom_range(0, 5)));
        else if (pick < 60)
            add_code(SEP_CODES[$urandom_range(0, 28)]);
        else if (pick < 75)
            text_q.push_back({1'b0, b0[6:0]});
        else if (pick < 85)
            add_code({16'h0, 3'b110, b0[4:0], 2'b10, b1[5:0]});
        else if (pick < 90)
            add_code({8'h0, 4'b1110, b0[3:0], 2'b10, b1[5:0], 2'b10, b2[5:0]});
        else if (pick < 95) begin
            // 4-byte lead followed by arbitrary bytes
            text_q.push_back({4'hf, b0[3:0]});
            text_q.push_back(b1);
            text_q.push_back(b2);
            text_q.push_back(b3);
        end else
            text_q.push_back(b0);
    endtask

    // receiver readiness, switching between patterns
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  i_m_tready <= 1'b1;
            RX_COIN:  i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_COMB:  i_m_tready <= (rx_tick % 3 != 0);
            RX_CHOKE: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : check_counts
        logic [OUT_BITS-1:0] exp_counts;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                exp_counts = pending_counts.pop_front();
                results_seen++;
                for (int k = 0; k <= NUM_VOWELS; k++) begin
                    if (exp_counts[k * OUT_WIDTH +: OUT_WIDTH] !==
                        o_m_tdata[k * OUT_WIDTH +: OUT_WIDTH]) begin
                        $display("%0t: %s expected %0d, actual %0d", $time, field_name(k),
                                 exp_counts[k * OUT_WIDTH +: OUT_WIDTH],
                                 o_m_tdata[k * OUT_WIDTH +: OUT_WIDTH]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_counts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int rand_bytes;
        int rand_chunks;
        int n_chars;
        int end_pick;
        t_stim_row r;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        rand_bytes  = 0;
        rand_chunks = 0;
        clear_text_state();

        // lone space right after reset: nothing counted
        add_pinned(8'h20, pack_counts(0, 0, 0, 0, 0, 0, 0));
        // "ai " then c3bd (u wins over y) closed by '.'
        add_row(8'h61, 0); add_row(8'h69, 0); add_row(8'h20, 0);
        add_row(8'hc3, 0); add_row(8'hbd, 0);
        add_pinned(8'h2e, pack_counts(2, 1, 0, 1, 0, 1, 0));
        // apostrophe-like codes do not close the word
        add_row(8'h6f, 0); add_row(8'h27, 0); add_row(8'h6f, 0); add_row(8'h60, 0);
        add_row(8'he2, 0); add_row(8'h80, 0); add_row(8'h98, 0);
        add_row(8'he2, 0); add_row(8'h80, 0); add_row(8'h99, 0);
        add_row(8'h79, 0); add_row(8'h20, 1);
        // c2af is i; open word and partial 4-byte char at the end are dropped
        add_row(8'hc2, 0); add_row(8'haf, 0); add_row(8'hff, 0); add_row(8'h00, 0);
        add_pinned(8'h80, pack_counts(0, 0, 0, 1, 0, 0, 0));
        // stray continuation byte is a one-byte other char
        add_row(8'h80, 0);
        add_pinned(8'h0a, pack_counts(1, 0, 0, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            send_byte(r.b, r.last, r.pin, r.want);
        end

        while (rand_bytes < 370 || rand_chunks < 35) begin
            text_q.delete();
            n_chars = $urandom_range(0, 12);
            repeat (n_chars) add_random_char();
            end_pick = $urandom_range(0, 99);
            if (end_pick < 70)
                add_code(SEP_CODES[$urandom_range(0, 28)]);
            else if (end_pick < 85)
                text_q.push_back({2'b11, 6'($urandom_range(0, 63))});
            if (text_q.size() == 0)
                text_q.push_back(8'($urandom_range(0, 255)));
            foreach (text_q[k])
                send_byte(text_q[k], k == text_q.size() - 1, 1'b0, '0);
            rand_bytes  += text_q.size();
            rand_chunks++;
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d chunks (directed cases, then %0d random chunks)",
                 bytes_sent, chunks_sent, rand_chunks);
        $display("Checked %0d count results, %0d field mismatches", results_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
